// ===== src/fault_table_aggregator_unit_assert.svh =====
// Assertion macros shared by the fault table checker.
`ifndef FAULT_TABLE_AGGREGATOR_UNIT_ASSERT_SVH
`define FAULT_TABLE_AGGREGATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FTAGG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FTAGG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ftagg_pkg.sv =====
// Shared constants, types and helpers of the fault table aggregator.
`timescale 1ns / 1ps

package ftagg_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // request codes
  localparam logic [1:0] REQ_REPORT     = 2'd0;
  localparam logic [1:0] REQ_CLEAR      = 2'd1;
  localparam logic [1:0] REQ_CLEAR_NODE = 2'd2;

  // severity codes
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_CRIT = 2'd2;

  // result status codes
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [7:0] node;
    logic [7:0] code;
    logic       active;
    logic [1:0] sev;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [7:0] sat_dec(logic [7:0] v);
    return (v == 8'h00) ? v : v - 8'd1;
  endfunction

endpackage

// ===== src/ftagg_ctrl.sv =====
// Sequencing controller: accept, scan, finish, deliver.
`timescale 1ns / 1ps

module ftagg_ctrl import ftagg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DELIVER
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   out_valid_q;
  logic   out_free;

  // output register can take a new result
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DELIVER && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
            stall_q <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.finish   = (state_q == ST_FINISH);
    cmd_o.load_out = (state_q == ST_DELIVER) && out_free;
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/ftagg_dp.sv =====
// Datapath: entry store, pipelined table scan, counters, result register.
`timescale 1ns / 1ps

module ftagg_dp import ftagg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] source_node_i,
  input  logic [7:0] fault_code_i,
  input  logic [1:0] severity_i,
  output logic       status_o,
  output logic       any_critical_o,
  output logic [7:0] active_entries_o,
  output logic [7:0] critical_total_o,
  output logic [7:0] warning_total_o,
  output logic [7:0] used_entries_o
);

  entry_t     mem_q [MAX_ENTRIES];

  // request under work
  logic [1:0] req_q;
  logic [7:0] node_q;
  logic [7:0] code_q;
  logic [1:0] sev_q;

  // scan pipeline: read stage, then check stage
  cnt_t       rd_idx_q, rd_idx_d;
  idx_t       chk_idx_q;
  logic       chk_vld_q;
  entry_t     rd_data_q;
  logic       found_q, found_d;
  logic       issue;
  logic       key_hit;

  // table bookkeeping
  cnt_t       used_q, used_d;
  cnt_t       act_q, act_d;
  logic [7:0] crit_q, crit_d;
  logic [7:0] warn_q, warn_d;
  logic       status_q, status_d;

  // store write port
  logic       wr_en;
  idx_t       wr_addr;
  entry_t     wr_data;

  // counter update
  logic       cnt_up, cnt_dn;
  logic [1:0] cnt_sev;
  logic       act_inc, act_dec;

  // result register
  logic       res_status_q;
  logic [7:0] res_act_q, res_crit_q, res_warn_q, res_used_q;

  assign issue   = cmd_i.scan && !found_q && (rd_idx_q < used_q);
  assign key_hit = cmd_i.scan && chk_vld_q && !found_q &&
                   (rd_data_q.node == node_q) &&
                   ((req_q == REQ_CLEAR_NODE) || (rd_data_q.code == code_q));

  assign sts_o.scan_done = found_q || (!chk_vld_q && (rd_idx_q >= used_q));

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = chk_idx_q;
    wr_data  = rd_data_q;
    found_d  = found_q;
    used_d   = used_q;
    status_d = status_q;
    cnt_up   = 1'b0;
    cnt_dn   = 1'b0;
    cnt_sev  = sev_q;
    act_inc  = 1'b0;
    act_dec  = 1'b0;
    rd_idx_d = issue ? rd_idx_q + cnt_t'(1) : rd_idx_q;

    unique case (req_q)
      REQ_REPORT: begin
        if (key_hit) begin
          wr_en          = 1'b1;
          wr_data.active = 1'b1;
          wr_data.sev    = sev_q;
          found_d        = 1'b1;
          if (!rd_data_q.active) begin
            cnt_up  = 1'b1;
            act_inc = 1'b1;
          end
        end
      end
      REQ_CLEAR, REQ_CLEAR_NODE: begin
        if (key_hit && rd_data_q.active) begin
          wr_en          = 1'b1;
          wr_data.active = 1'b0;
          cnt_dn         = 1'b1;
          cnt_sev        = rd_data_q.sev;
          act_dec        = 1'b1;
          // clear stops at its first hit, clear-node walks the whole table
          if (req_q == REQ_CLEAR) begin
            found_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (cmd_i.finish) begin
      status_d = STAT_DONE;
      if (req_q == REQ_REPORT && !found_q) begin
        if (used_q < cnt_t'(MAX_ENTRIES)) begin
          // append a new active entry
          wr_en   = 1'b1;
          wr_addr = used_q[IDX_W-1:0];
          wr_data = '{node: node_q, code: code_q, active: 1'b1, sev: sev_q};
          used_d  = used_q + cnt_t'(1);
          cnt_up  = 1'b1;
          act_inc = 1'b1;
        end else begin
          status_d = STAT_FULL;
        end
      end
    end

    act_d = act_q;
    if (act_inc) begin
      act_d = act_q + cnt_t'(1);
    end else if (act_dec) begin
      act_d = act_q - cnt_t'(1);
    end
  end

  always_comb begin
    crit_d = crit_q;
    warn_d = warn_q;
    if (cnt_up) begin
      if (cnt_sev == SEV_CRIT) begin
        crit_d = sat_inc(crit_q);
      end else if (cnt_sev == SEV_WARN) begin
        warn_d = sat_inc(warn_q);
      end
    end else if (cnt_dn) begin
      if (cnt_sev == SEV_CRIT) begin
        crit_d = sat_dec(crit_q);
      end else if (cnt_sev == SEV_WARN) begin
        warn_d = sat_dec(warn_q);
      end
    end
  end

  // entry store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
      chk_idx_q <= rd_idx_q[IDX_W-1:0];
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= req_type_i;
      node_q <= source_node_i;
      code_q <= fault_code_i;
      sev_q  <= severity_i;
    end
    status_q <= status_d;
    if (cmd_i.load_out) begin
      res_status_q <= status_q;
      res_act_q    <= 8'(act_q);
      res_crit_q   <= crit_q;
      res_warn_q   <= warn_q;
      res_used_q   <= 8'(used_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      used_q    <= '0;
      act_q     <= '0;
      crit_q    <= '0;
      warn_q    <= '0;
    end else begin
      used_q <= used_d;
      act_q  <= act_d;
      crit_q <= crit_d;
      warn_q <= warn_d;
      if (cmd_i.start) begin
        rd_idx_q  <= '0;
        chk_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end else begin
        rd_idx_q  <= rd_idx_d;
        chk_vld_q <= issue;
        found_q   <= found_d;
      end
    end
  end

  assign status_o         = res_status_q;
  assign any_critical_o   = (res_crit_q != 8'd0);
  assign active_entries_o = res_act_q;
  assign critical_total_o = res_crit_q;
  assign warning_total_o  = res_warn_q;
  assign used_entries_o   = res_used_q;

endmodule

// ===== src/fault_table_aggregator_unit.sv =====
// From input transfer to result valid a request passes the scan pipeline (read and check
//   stages), the finish step and the result load, which waits for a free output register.
// One request at a time: the serial scan over the entry store, one read per cycle through
//   its single registered read port, and the result load finish before a new request is taken.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst_ni, async, active low) empties the table and zeroes both counters;
//   store contents are not cleared, only slots below the fill count are ever read.
`timescale 1ns / 1ps

module fault_table_aggregator_unit import ftagg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] source_node_i,
  input  logic [7:0] fault_code_i,
  input  logic [1:0] severity_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_o,
  output logic       any_critical_o,
  output logic [7:0] active_entries_o,
  output logic [7:0] critical_total_o,
  output logic [7:0] warning_total_o,
  output logic [7:0] used_entries_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller: walks IDLE -> SCAN -> FINISH -> DELIVER. Owns both handshakes.
  ftagg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: scan pipeline reads one slot per cycle, a check stage
  // compares the key and writes back the active bit / severity.
  // Finish step appends a new entry for an unmatched report or flags a full table.
  ftagg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .source_node_i    (source_node_i),
    .fault_code_i     (fault_code_i),
    .severity_i       (severity_i),
    .status_o         (status_o),
    .any_critical_o   (any_critical_o),
    .active_entries_o (active_entries_o),
    .critical_total_o (critical_total_o),
    .warning_total_o  (warning_total_o),
    .used_entries_o   (used_entries_o)
  );

endmodule

// ===== src/ftagg_chk.sv =====
// Port-level checker for the fault table aggregator, bound to the top level.
`timescale 1ns / 1ps
`include "fault_table_aggregator_unit_assert.svh"

module ftagg_chk import ftagg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       status_o,
  input logic       any_critical_o,
  input logic [7:0] active_entries_o,
  input logic [7:0] critical_total_o,
  input logic [7:0] used_entries_o
);

  `FTAGG_ASSERT_IMP(a_crit_flag, out_valid_o, any_critical_o == (critical_total_o != 8'd0), "any_critical disagrees with critical_total")
  `FTAGG_ASSERT_IMP(a_active_le_used, out_valid_o, active_entries_o <= used_entries_o, "more active entries than used slots")
  `FTAGG_ASSERT_IMP(a_used_bound, out_valid_o, used_entries_o <= 8'(MAX_ENTRIES), "used entries above table size")
  `FTAGG_ASSERT_IMP(a_full_only_when_full, out_valid_o && status_o == STAT_FULL, used_entries_o == 8'(MAX_ENTRIES), "table full reported on a table with free slots")
  `FTAGG_ASSERT_NXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(active_entries_o) && $stable(critical_total_o), "stalled result changed")

endmodule

bind fault_table_aggregator_unit ftagg_chk u_ftagg_chk (.*);

// ===== tb/fault_table_aggregator_unit_tb.sv =====
// Self-checking testbench for the fault table aggregator unit.
`timescale 1ns / 1ps

module fault_table_aggregator_unit_tb;
  import ftagg_pkg::*;

  // Request code 3 has no meaning; the block must leave its state alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Severities that count toward neither counter.
  localparam logic [1:0] SEV_NONE  = 2'd0;
  localparam logic [1:0] SEV_OTHER = 2'd3;

  localparam int unsigned RANDOM_ITEMS    = 1340;
  // Random rounds push both counters toward 255 until this many transfers.
  localparam int unsigned CLIMB_BUDGET    = 1150;
  localparam int unsigned HOLD_OFF_AFTER  = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Worst case latency is a full scan (16 slots) plus finish.
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // One result transfer, in port order.
  typedef struct packed {
    logic       status;
    logic       any_critical;
    logic [7:0] active_entries;
    logic [7:0] critical_total;
    logic [7:0] warning_total;
    logic [7:0] used_entries;
  } fault_summary_t;

  // -------------------------------------------------------------------------
  // Fault table tracker: mirrors the entry store and both counters, and
  // queues the summary that every accepted request must produce.
  // -------------------------------------------------------------------------
  class fault_table_tracker;
    logic [7:0]     slot_node [MAX_ENTRIES];
    logic [7:0]     slot_code [MAX_ENTRIES];
    bit             slot_on   [MAX_ENTRIES];
    logic [1:0]     slot_sev  [MAX_ENTRIES];
    int unsigned    fill_count;
    logic [7:0]     crit_level;
    logic [7:0]     warn_level;
    fault_summary_t pending_summaries[$];
    int unsigned    accepted;
    int unsigned    fail_count;

    function new();
      fill_count = 0;
      crit_level = 8'd0;
      warn_level = 8'd0;
      accepted   = 0;
      fail_count = 0;
    endfunction

    function void bump_up(logic [1:0] sev);
      if (sev == SEV_CRIT) begin
        if (crit_level != 8'hFF) crit_level++;
      end else if (sev == SEV_WARN) begin
        if (warn_level != 8'hFF) warn_level++;
      end
    endfunction

    function void bump_down(logic [1:0] sev);
      if (sev == SEV_CRIT) begin
        if (crit_level != 8'h00) crit_level--;
      end else if (sev == SEV_WARN) begin
        if (warn_level != 8'h00) warn_level--;
      end
    endfunction

    // clears count down by the stored severity, not the requested one
    function void retire(int idx);
      bump_down(slot_sev[idx]);
      slot_on[idx] = 1'b0;
    endfunction

    function void note_request(logic [1:0] req, logic [7:0] node, logic [7:0] code,
                               logic [1:0] sev);
      fault_summary_t want;
      int             hit;
      int unsigned    live;
      want.status = STAT_DONE;
      hit         = -1;
      live        = 0;
      accepted++;
      case (req)
        REQ_REPORT: begin
          for (int i = 0; i < fill_count; i++)
            if (hit < 0 && slot_node[i] == node && slot_code[i] == code) hit = i;
          if (hit >= 0) begin
            // known key: reactivate if needed, severity always follows the report
            if (!slot_on[hit]) begin
              slot_on[hit] = 1'b1;
              bump_up(sev);
            end
            slot_sev[hit] = sev;
          end else if (fill_count >= MAX_ENTRIES) begin
            want.status = STAT_FULL;
          end else begin
            slot_node[fill_count] = node;
            slot_code[fill_count] = code;
            slot_on[fill_count]   = 1'b1;
            slot_sev[fill_count]  = sev;
            fill_count++;
            bump_up(sev);
          end
        end
        REQ_CLEAR: begin
          for (int i = 0; i < fill_count; i++)
            if (hit < 0 && slot_on[i] && slot_node[i] == node && slot_code[i] == code) begin
              retire(i);
              hit = i;
            end
        end
        REQ_CLEAR_NODE: begin
          for (int i = 0; i < fill_count; i++)
            if (slot_on[i] && slot_node[i] == node) retire(i);
        end
        default: ;
      endcase
      for (int i = 0; i < fill_count; i++)
        if (slot_on[i]) live++;
      want.any_critical   = (crit_level != 8'd0);
      want.active_entries = 8'(live);
      want.critical_total = crit_level;
      want.warning_total  = warn_level;
      want.used_entries   = 8'(fill_count);
      pending_summaries.push_back(want);
    endfunction

    function string show(fault_summary_t s);
      return $sformatf("st=%0d crit=%0d act=%0d ct=%0d wt=%0d used=%0d", s.status,
                       s.any_critical, s.active_entries, s.critical_total,
                       s.warning_total, s.used_entries);
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] ERROR %s", $realtime, msg);
    endfunction

    function void check_summary(fault_summary_t got);
      fault_summary_t want;
      string          diffs;
      diffs = "";
      if (pending_summaries.size() == 0) begin
        flag({"result with nothing expected: ", show(got)});
        return;
      end
      want = pending_summaries.pop_front();
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.any_critical !== want.any_critical) diffs = {diffs, " any_critical"};
      if (got.active_entries !== want.active_entries) diffs = {diffs, " active_entries"};
      if (got.critical_total !== want.critical_total) diffs = {diffs, " critical_total"};
      if (got.warning_total !== want.warning_total) diffs = {diffs, " warning_total"};
      if (got.used_entries !== want.used_entries) diffs = {diffs, " used_entries"};
      if (diffs != "")
        flag({"mismatch on", diffs, ": exp ", show(want), " got ", show(got)});
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block
  // -------------------------------------------------------------------------
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [1:0] req_type_i    = REQ_REPORT;
  logic [7:0] source_node_i = 8'd0;
  logic [7:0] fault_code_i  = 8'd0;
  logic [1:0] severity_i    = SEV_NONE;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic       status_o;
  logic       any_critical_o;
  logic [7:0] active_entries_o;
  logic [7:0] critical_total_o;
  logic [7:0] warning_total_o;
  logic [7:0] used_entries_o;

  fault_table_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned well_formed = 0;  // random transfers that count toward RANDOM_ITEMS
  int unsigned burst_left  = 0;
  bit          no_gaps     = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fault_table_aggregator_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .source_node_i    (source_node_i),
    .fault_code_i     (fault_code_i),
    .severity_i       (severity_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .any_critical_o   (any_critical_o),
    .active_entries_o (active_entries_o),
    .critical_total_o (critical_total_o),
    .warning_total_o  (warning_total_o),
    .used_entries_o   (used_entries_o)
  );

  // -------------------------------------------------------------------------
  // Key pool: two nodes at the extremes, eight codes each, so the pool
  // fills the table exactly and every key bit takes both values.
  // -------------------------------------------------------------------------
  function automatic logic [7:0] node_of(int k);
    return (k != 0) ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [7:0] code_of(int k);
    case (k)
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      3:       return 8'h80;
      4:       return 8'h55;
      5:       return 8'hAA;
      6:       return 8'h7F;
      default: return 8'h0F;
    endcase
  endfunction

  // Severity for a report that may activate an entry. While climbing, the
  // counter still short of 255 gets it; otherwise lean to uncounted values.
  function automatic logic [1:0] raise_sev(bit climbing);
    if ($urandom_range(0, 99) < 85) begin
      if (climbing) return (tracker.crit_level != 8'hFF) ? SEV_CRIT : SEV_WARN;
      return $urandom_range(0, 1) ? SEV_NONE : SEV_OTHER;
    end
    return 2'($urandom_range(0, 3));
  endfunction

  // Severity for a report on a (mostly) active key. While climbing, retag to
  // an uncounted value so the later clear leaves the counters where they are.
  function automatic logic [1:0] retag_sev(bit climbing);
    if ($urandom_range(0, 99) < 85) begin
      if (climbing) return $urandom_range(0, 1) ? SEV_NONE : SEV_OTHER;
      return $urandom_range(0, 1) ? SEV_CRIT : SEV_WARN;
    end
    return 2'($urandom_range(0, 3));
  endfunction

  // -------------------------------------------------------------------------
  // Request side: drive at the falling edge, hold until a transfer, then
  // idle according to the burst pattern.
  // -------------------------------------------------------------------------
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 11);
    end
  endtask

  task automatic send_item(logic [1:0] req, logic [7:0] node, logic [7:0] code,
                           logic [1:0] sev, bit counted);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    source_node_i <= node;
    fault_code_i  <= code;
    severity_i    <= sev;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_request(req, node, code, sev);
    if (counted) well_formed++;
    pace();
  endtask

  // Stray traffic: unused codes, keys outside the pool (table full once
  // the pool is in), clears that match nothing.
  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 6) begin
      case ($urandom_range(0, 3))
        0: send_item(REQ_UNUSED, 8'($urandom), 8'($urandom), 2'($urandom), 1'b0);
        1: send_item(REQ_REPORT, 8'($urandom), 8'($urandom), 2'($urandom), 1'b0);
        2: send_item(REQ_CLEAR, 8'($urandom), 8'($urandom), 2'($urandom), 1'b0);
        default: send_item(REQ_CLEAR_NODE, 8'($urandom), 8'($urandom), 2'($urandom), 1'b0);
      endcase
    end
  endtask

  task automatic run_directed();
    // single key: new entry, severity change while active, clear with the
    // critical counter already at zero, clear with no active match
    send_item(REQ_REPORT, node_of(0), code_of(0), SEV_NONE, 1'b0);
    send_item(REQ_REPORT, node_of(0), code_of(0), SEV_CRIT, 1'b0);
    send_item(REQ_CLEAR, node_of(0), code_of(0), SEV_NONE, 1'b0);
    send_item(REQ_CLEAR, node_of(0), code_of(0), SEV_WARN, 1'b0);
    // reactivation counts with the reported severity
    send_item(REQ_REPORT, node_of(0), code_of(0), SEV_CRIT, 1'b0);
    send_item(REQ_UNUSED, 8'hFF, 8'hFF, SEV_OTHER, 1'b0);
    // fill the rest of the table, all four severities
    for (int n = 0; n < 2; n++)
      for (int c = 0; c < 8; c++)
        if (n != 0 || c != 0)
          send_item(REQ_REPORT, node_of(n), code_of(c), 2'((n * 8 + c) % 4), 1'b0);
    // new key on a full table is rejected; a known key still updates
    send_item(REQ_REPORT, 8'h5A, 8'hC3, SEV_CRIT, 1'b0);
    send_item(REQ_REPORT, node_of(1), code_of(7), SEV_WARN, 1'b0);
    // clear node ignores the fault code
    send_item(REQ_CLEAR_NODE, node_of(1), 8'hA5, SEV_OTHER, 1'b0);
  endtask

  // One round works a node through activate, retag and clear.
  task automatic run_round();
    logic [7:0] node;
    int         off;
    bit         climbing;
    node     = node_of($urandom_range(0, 1));
    off      = $urandom_range(0, 7);
    climbing = (tracker.crit_level != 8'hFF || tracker.warn_level != 8'hFF) &&
               (well_formed < CLIMB_BUDGET);
    no_gaps  = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 99) < 85)
        send_item(REQ_REPORT, node, code_of((k + off) % 8), raise_sev(climbing), 1'b1);
      maybe_noise();
    end
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 99) < 75)
        send_item(REQ_REPORT, node, code_of((k * 3 + off) % 8), retag_sev(climbing), 1'b1);
      maybe_noise();
    end
    if ($urandom_range(0, 99) < 70) begin
      send_item(REQ_CLEAR_NODE, node, 8'($urandom), 2'($urandom), 1'b1);
    end else begin
      for (int k = 0; k < 8; k++)
        if ($urandom_range(0, 99) < 70)
          send_item(REQ_CLEAR, node, code_of(k), 2'($urandom), 1'b1);
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: stall pattern changes every stretch; once, a long hold-off
  // backs the block up so its input stalls too.
  // -------------------------------------------------------------------------
  initial begin : result_backpressure
    int unsigned pattern;
    int unsigned span;
    int unsigned tick;
    bit          held_off;
    held_off = 1'b0;
    tick     = 0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && tracker.accepted >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        pattern = $urandom_range(0, 3);
        span    = $urandom_range(20, 200);
        repeat (span) begin
          @(negedge clk_i);
          tick++;
          case (pattern)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 99) < 30);
            2:       out_stall_i <= ($urandom_range(0, 99) < 75);
            default: out_stall_i <= (tick % 5 < 2);
          endcase
        end
      end
    end
  end

  // Every result transfer is checked against the oldest expected summary.
  always @(posedge clk_i) begin : result_monitor
    fault_summary_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, any_critical_o, active_entries_o, critical_total_o,
             warning_total_o, used_entries_o};
      tracker.check_summary(got);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    while (well_formed < RANDOM_ITEMS) run_round();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // all transfers accepted: wait out the results, then a quiet window to
    // catch anything extra
    while (tracker.pending_summaries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
